// File: hw/rtl/snr_pkg.sv
package snr_pkg;

   localparam int TARGET_W = 12;
   localparam int SMOOTH_W = 40;
   localparam int NUM_PTR  = 3;

   // multipliers of the three read positions, in the order two, three, five
   localparam int FACTORS [NUM_PTR] = '{2, 3, 5};

   typedef logic [NUM_PTR-1:0] ptr_set_type;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_GROW = 5'b00010,
      S_PICK = 5'b00100,
      S_WAIT = 5'b01000,
      S_LOAD = 5'b10000
   } state_type;

endpackage

// File: hw/rtl/snr_if.sv
interface snr_req_if import snr_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [TARGET_W-1:0] target_index;

   modport source (output valid, output target_index, input ready);
   modport sink (input valid, input target_index, output ready);
endinterface

interface snr_rsp_if import snr_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SMOOTH_W-1:0] smooth_value;

   modport source (output valid, output smooth_value, input ready);
   modport sink (input valid, input smooth_value, output ready);
endinterface

// File: hw/rtl/snr_table.sv
module snr_table #(
   parameter int DEPTH  = 2048,
   parameter int DATA_W = 40,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // one write and one registered read per cycle, no reset on contents
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/snr_satmul.sv
module snr_satmul #(
   parameter int VALUE_BITS = 40,
   parameter int FACTOR     = 2
) (
   input  logic [VALUE_BITS-1:0] value,
   output logic [VALUE_BITS-1:0] product
);

   localparam logic [VALUE_BITS-1:0] VALUE_MAX = '1;
   localparam logic [VALUE_BITS-1:0] LIMIT     = VALUE_MAX / VALUE_BITS'(FACTOR);

   logic [VALUE_BITS-1:0] wide;

   // constant multiply, clamped to all ones when the result would not fit
   assign wide    = value * VALUE_BITS'(FACTOR);
   assign product = (value > LIMIT) ? VALUE_MAX : wide;

endmodule

// File: hw/rtl/smooth_number_generator_core.sv
// Returns the n-th number whose only prime factors are 2, 3 and 5 (1 is the first),
// for a one-based index on the request beat; index 0 gives 0 and indices above
// MAX_INDEX are clamped to MAX_INDEX. The ascending sequence lives in a table with
// one write port and one registered read port that grows on demand and is kept
// across requests, so a request for a position already built is only read back.
// Each new entry is appended, and then every step of a read position takes a read
// and a compare, one step at a time as the single table read port sets; each of
// the three positions steps nearly once per entry. Once products clamp to all ones
// the positions walk up to the newest entry one step at a time and appends slow
// down accordingly. There is no clearing pass after reset. One request is worked
// on at a time; a finished result sits in an output register, and the next
// request is taken while it waits.
module smooth_number_generator_core import snr_pkg::*; #(
   parameter int MAX_INDEX  = 2048,
   parameter int VALUE_BITS = 40
) (
   input  logic clock,
   input  logic reset,
   snr_req_if.sink   req,
   snr_rsp_if.source rsp
);

   localparam int ADDR_W = (MAX_INDEX > 1) ? $clog2(MAX_INDEX) : 1;
   localparam int CNT_W  = $clog2(MAX_INDEX + 1);
   localparam int REQ_W  = TARGET_W + 1;

   // control state
   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;
   logic [ADDR_W-1:0]  p_ff [NUM_PTR];
   logic [ADDR_W-1:0]  p_in [NUM_PTR];
   ptr_set_type        flag_ff, flag_in;
   ptr_set_type        cur_ff, cur_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // payload
   logic [VALUE_BITS-1:0] prod_ff [NUM_PTR];
   logic [VALUE_BITS-1:0] prod_in [NUM_PTR];
   logic [VALUE_BITS-1:0] m_ff, m_in;
   logic [ADDR_W-1:0]     lim_ff, lim_in;
   logic [CNT_W-1:0]      n_ff, n_in;
   logic                  zero_ff, zero_in;
   logic [SMOOTH_W-1:0]   rsp_data_ff, rsp_data_in;

   // table port and datapath
   logic                  wr_en, rd_en;
   logic [ADDR_W-1:0]     wr_addr, rd_addr;
   logic [VALUE_BITS-1:0] wr_data, rd_data;
   logic [VALUE_BITS-1:0] sat [NUM_PTR];
   logic [VALUE_BITS-1:0] min_ab, min_val;
   ptr_set_type           grow_flag, pick_oh;
   logic [CNT_W-1:0]      req_n;
   logic                  req_beat;

   snr_table #(
      .DEPTH  (MAX_INDEX),
      .DATA_W (VALUE_BITS),
      .ADDR_W (ADDR_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // clamped products of the freshly read entry, one per read position
   for (genvar g = 0; g < NUM_PTR; g++) begin : g_mul
      snr_satmul #(
         .VALUE_BITS (VALUE_BITS),
         .FACTOR     (FACTORS[g])
      ) u_mul (
         .value   (rd_data),
         .product (sat[g])
      );
   end

   assign req.ready     = (state_ff == S_IDLE);
   assign req_beat      = req.valid && (state_ff == S_IDLE);
   assign rsp.valid     = rsp_valid_ff;
   assign rsp.smooth_value = rsp_data_ff;

   // index clamped to the table depth
   assign req_n = ({1'b0, req.target_index} > REQ_W'(MAX_INDEX)) ?
                  CNT_W'(MAX_INDEX) : CNT_W'(req.target_index);

   // next entry is the least of the three cached products
   assign min_ab  = (prod_ff[0] < prod_ff[1]) ? prod_ff[0] : prod_ff[1];
   assign min_val = (prod_ff[2] < min_ab) ? prod_ff[2] : min_ab;

   // positions whose product does not exceed the new entry step forward
   always_comb begin
      for (int k = 0; k < NUM_PTR; k++) begin
         grow_flag[k] = (prod_ff[k] <= min_val) && (CNT_W'(p_ff[k]) < fill_ff);
      end
   end

   // lowest position still waiting to step
   assign pick_oh = flag_ff & ~(flag_ff - ptr_set_type'(1));

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      p_in         = p_ff;
      flag_in      = flag_ff;
      cur_in       = cur_ff;
      prod_in      = prod_ff;
      m_in         = m_ff;
      lim_in       = lim_ff;
      n_in         = n_ff;
      zero_in      = zero_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = '0;
      rd_en        = 1'b0;
      rd_addr      = '0;

      // result register empties on its beat
      if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_beat) begin
               if (req.target_index == '0) begin
                  // index zero answers 0 and leaves the table alone
                  zero_in  = 1'b1;
                  state_in = S_LOAD;
               end else begin
                  zero_in  = 1'b0;
                  n_in     = req_n;
                  state_in = S_GROW;
                  if (fill_ff == '0) begin
                     // seed the table with 1; the products of 1 are the factors
                     wr_en   = 1'b1;
                     wr_addr = '0;
                     wr_data = VALUE_BITS'(1);
                     fill_in = CNT_W'(1);
                     for (int k = 0; k < NUM_PTR; k++) begin
                        p_in[k]    = '0;
                        prod_in[k] = VALUE_BITS'(FACTORS[k]);
                     end
                  end
               end
            end
         end

         S_GROW: begin
            if (fill_ff >= n_ff) begin
               // wanted entry already built: fetch it
               rd_en    = 1'b1;
               rd_addr  = ADDR_W'(n_ff - CNT_W'(1));
               state_in = S_LOAD;
            end else begin
               // append the least product and mark the positions to step
               wr_en    = 1'b1;
               wr_addr  = ADDR_W'(fill_ff);
               wr_data  = min_val;
               m_in     = min_val;
               lim_in   = ADDR_W'(fill_ff);
               flag_in  = grow_flag;
               fill_in  = fill_ff + CNT_W'(1);
               state_in = (|grow_flag) ? S_PICK : S_GROW;
            end
         end

         S_PICK: begin
            // step one position and read the entry it now points at
            rd_en  = 1'b1;
            cur_in = pick_oh;
            for (int k = 0; k < NUM_PTR; k++) begin
               if (pick_oh[k]) begin
                  p_in[k] = p_ff[k] + ADDR_W'(1);
                  rd_addr = p_ff[k] + ADDR_W'(1);
               end
            end
            state_in = S_WAIT;
         end

         S_WAIT: begin
            // refresh its product and test whether it must step again
            for (int k = 0; k < NUM_PTR; k++) begin
               if (cur_ff[k]) begin
                  prod_in[k] = sat[k];
                  flag_in[k] = (sat[k] <= m_ff) && (p_ff[k] < lim_ff);
               end
            end
            state_in = (|flag_in) ? S_PICK : S_GROW;
         end

         S_LOAD: begin
            // read data holds until the result register is free
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = zero_ff ? '0 : SMOOTH_W'(rd_data);
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         p_ff         <= '{default: '0};
         flag_ff      <= '0;
         cur_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         p_ff         <= p_in;
         flag_ff      <= flag_in;
         cur_ff       <= cur_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff     <= prod_in;
      m_ff        <= m_in;
      lim_ff      <= lim_in;
      n_ff        <= n_in;
      zero_ff     <= zero_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef ASSERT_OFF
   // read positions always point inside the built part of the table
   a_ptr_in_table: assert property (@(posedge clock) disable iff (reset)
      (fill_ff != '0) |-> ((CNT_W'(p_ff[0]) < fill_ff) && (CNT_W'(p_ff[1]) < fill_ff) &&
                           (CNT_W'(p_ff[2]) < fill_ff)))
      else $error("read position beyond built table");

   // an append grows the table by exactly one entry
   a_grow_append: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_GROW && fill_ff < n_ff) |=> (fill_ff == $past(fill_ff) + CNT_W'(1)))
      else $error("append did not advance fill count by one");

   // index zero delivers a zero result beat
   a_zero_answer: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOAD && zero_ff && (!rsp_valid_ff || rsp.ready))
      |=> (rsp.valid && rsp.smooth_value == '0))
      else $error("index zero did not answer zero");
`endif

endmodule

// File: sim/snr_checker.sv
`timescale 1ns / 100ps

module snr_checker import snr_pkg::*; #(
   parameter int MAX_INDEX = 2048
) (
   input  logic clock,
   input  logic reset,
   snr_req_if   req_bus,
   snr_rsp_if   rsp_bus,
   output int   fail_count,
   output int   pending
);

   // own copy of the growing sequence and its three read positions
   logic [SMOOTH_W-1:0] seq_mem [MAX_INDEX];
   int unsigned         fill_cnt;
   int unsigned         pos_two;
   int unsigned         pos_three;
   int unsigned         pos_five;

   logic [SMOOTH_W-1:0] smooth_due [$];
   int                  errors = 0;

   function automatic logic [SMOOTH_W-1:0] clamp_mul(input logic [SMOOTH_W-1:0] v,
                                                     input int unsigned k);
      logic [SMOOTH_W+3:0] wide;
      wide = {4'b0, v} * (SMOOTH_W+4)'(k);
      if (wide[SMOOTH_W+3:SMOOTH_W] != '0) return '1;
      return wide[SMOOTH_W-1:0];
   endfunction

   function automatic int unsigned step_pos(input int unsigned p, input int unsigned k,
                                            input logic [SMOOTH_W-1:0] entry,
                                            input int unsigned limit);
      int unsigned q;
      q = p;
      while (q < limit && clamp_mul(seq_mem[q], k) <= entry) q++;
      return q;
   endfunction

   function automatic void append_entry();
      logic [SMOOTH_W-1:0] a, b, c, m;
      int unsigned i;
      i = fill_cnt;
      a = clamp_mul(seq_mem[pos_two], FACTORS[0]);
      b = clamp_mul(seq_mem[pos_three], FACTORS[1]);
      c = clamp_mul(seq_mem[pos_five], FACTORS[2]);
      m = (a < b) ? a : b;
      if (c < m) m = c;
      seq_mem[i] = m;
      pos_two   = step_pos(pos_two, FACTORS[0], m, i);
      pos_three = step_pos(pos_three, FACTORS[1], m, i);
      pos_five  = step_pos(pos_five, FACTORS[2], m, i);
      fill_cnt  = i + 1;
   endfunction

   function automatic logic [SMOOTH_W-1:0] predict_smooth(input logic [TARGET_W-1:0] idx);
      int unsigned n;
      n = idx;
      if (n == 0) return '0;
      if (n > MAX_INDEX) n = MAX_INDEX;
      if (fill_cnt == 0) begin
         seq_mem[0] = 1;
         pos_two    = 0;
         pos_three  = 0;
         pos_five   = 0;
         fill_cnt   = 1;
      end
      while (fill_cnt < n) append_entry();
      return seq_mem[n-1];
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
   endtask

   always @(posedge clock) begin : watch
      logic [SMOOTH_W-1:0] want;
      if (reset) begin
         fill_cnt  = 0;
         pos_two   = 0;
         pos_three = 0;
         pos_five  = 0;
         smooth_due.delete();
      end else begin
         if (req_bus.valid && req_bus.ready)
            smooth_due.push_back(predict_smooth(req_bus.target_index));
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (smooth_due.size() == 0) begin
               report_mismatch($sformatf("unexpected result beat, smooth_value %0d",
                                         rsp_bus.smooth_value));
            end else begin
               want = smooth_due.pop_front();
               if (rsp_bus.smooth_value !== want)
                  report_mismatch($sformatf("smooth_value %0d, wanted %0d",
                                            rsp_bus.smooth_value, want));
            end
         end
      end
      pending    <= smooth_due.size();
      fail_count <= errors;
   end

endmodule

// File: sim/tb_smooth_number_generator_core.sv
`timescale 1ns / 100ps

module tb_smooth_number_generator_core;
   import snr_pkg::*;

   logic clock;
   logic reset;

   snr_req_if req_ch ();
   snr_rsp_if rsp_ch ();

   int fail_count;
   int pending;

   // idle-length state per side: while non-zero the side runs without gaps
   int calm_req = 0;
   int calm_rsp = 0;

   smooth_number_generator_core DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   // watches both channels, predicts every result and counts mismatches
   snr_checker #(.MAX_INDEX(2048)) u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_ch),
      .rsp_bus    (rsp_ch),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // mostly short gaps, a few long ones, and now and then a calm stretch with none
   function automatic int pick_gap(inout int calm);
      int roll;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 6) begin
         calm = $urandom_range(8, 30);
         return 0;
      end
      if (roll < 50) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(30, 200);
   endfunction

   // one request beat: optional idle gap, then hold valid until the block takes it;
   // valid is only lowered when a gap follows, so back-to-back beats keep it high
   task automatic send_index(input logic [TARGET_W-1:0] idx);
      int gap;
      gap = pick_gap(calm_req);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.target_index <= idx;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // result side: random stalls of ready, each released until one beat is taken
   initial begin : rsp_side
      int stall;
      @(negedge reset);
      forever begin
         stall = pick_gap(calm_rsp);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   initial begin : stimulus
      // small positions first, with repeats, zeros and out-of-order look-ups,
      // so the table is still short while the early cases are hit
      int opening [16] = '{0, 1, 2, 3, 1, 4, 5, 6, 7, 0, 12, 8, 30, 29, 60, 100};
      // top of the table, clamping above it, the all-ones index and a look-back
      int extremes [7] = '{2047, 2048, 2049, 4095, 2048, 1, 0};
      int frontier;
      int roll;
      int idx;

      clock               = 1'b0;
      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.target_index = '0;
      rsp_ch.ready        = 1'b0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (opening[i]) send_index(TARGET_W'(opening[i]));

      // growth phase: mostly pushes the built part forward by a random step,
      // with look-ups into the built part and a few zero indices mixed in
      frontier = 100;
      repeat (72) begin
         roll = $urandom_range(0, 99);
         if (roll < 70) begin
            frontier = frontier + $urandom_range(1, 50);
            if (frontier > 2048) frontier = 2048;
            idx = frontier;
         end else if (roll < 90) begin
            idx = $urandom_range(1, frontier);
         end else begin
            idx = 0;
         end
         send_index(TARGET_W'(idx));
      end

      foreach (extremes[i]) send_index(TARGET_W'(extremes[i]));

      // table is full now: the whole index field, clamped ones included
      repeat (45) begin
         roll = $urandom_range(0, 99);
         if (roll < 60) idx = $urandom_range(0, 4095);
         else idx = $urandom_range(1, 2048);
         send_index(TARGET_W'(idx));
      end

      req_ch.valid <= 1'b0;
      // let the checker see the last accepted beat before looking at its backlog
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   // watchdog: several times the slowest legal run, full table build included
   initial begin : watchdog
      #10_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
